// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short-hand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// trq_pkg
// Shared types and codes of the thread ready queue.
// ----------------------------------------------------------------------------
package trq_pkg;

  localparam int unsigned IdW           = 4;
  localparam int unsigned KindW         = 2;
  localparam int unsigned MaxThreadsDef = 16;

  // operation codes
  localparam logic [KindW-1:0] KindAppend = 2'd0;
  localparam logic [KindW-1:0] KindTake   = 2'd1;
  localparam logic [KindW-1:0] KindRemove = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   thread_id;
  } trq_item_t;

  typedef struct packed {
    logic           taken_valid;
    logic [IdW-1:0] taken_id;
    logic           now_empty;
  } trq_result_t;

  // link entry: clear valid means no neighbour
  typedef struct packed {
    logic           valid;
    logic [IdW-1:0] idx;
  } trq_link_t;

  // read addresses broadcast along the cell row
  typedef struct packed {
    logic [IdW-1:0] addr_a;  // next-link read
    logic [IdW-1:0] addr_b;  // prev-link read
  } trq_rd_t;

  // write commands broadcast along the cell row; nxt1 wins over nxt0
  typedef struct packed {
    logic           nxt0_en;
    logic [IdW-1:0] nxt0_addr;
    trq_link_t      nxt0_data;
    logic           nxt1_en;
    logic [IdW-1:0] nxt1_addr;
    trq_link_t      nxt1_data;
    logic           prv_en;
    logic [IdW-1:0] prv_addr;
    trq_link_t      prv_data;
  } trq_wr_t;

endpackage

// ===== design/thread_ready_queue.sv =====
// ----------------------------------------------------------------------------
// thread_ready_queue
// FIFO of thread ids kept as a doubly linked list spread over a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a word (kind, thread_id) is taken at a rising edge with
//    start high and busy low. kind: append at tail, take from head, or
//    remove a given thread from anywhere in the list.
//  - Result channel: done_o is high for exactly one cycle with the result
//    word (taken_valid, taken_id, now_empty). The receiver cannot stall;
//    the word stays on result_o until the next update replaces it.
//  - Timing: a read state fetches the neighbour links along the cell row, the
//    update state after it writes links, head and tail. The result appears in
//    the cycle after the update. busy is high only in the read state, so a new
//    command can be taken during the update of the last one, but not while its
//    links are read through the cell row.
//  - Reset (rst_ni low, asynchronous): queue empty, head and tail zero, no
//    result pending. Link cells are not cleared; an entry is to be read only
//    after an append has written it, which the block itself does not enforce.
//  - Each cell holds the next and prev link of one thread id; reads are OR-
//    folded from cell to cell, writes are broadcast to all cells.
// ----------------------------------------------------------------------------
module thread_ready_queue #(
  parameter int unsigned MaxThreads = trq_pkg::MaxThreadsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  trq_pkg::trq_item_t   item_i,
  output logic                 done_o,
  output trq_pkg::trq_result_t result_o
);

  trq_pkg::trq_rd_t   rd;
  trq_pkg::trq_wr_t   wr;
  trq_pkg::trq_link_t next_chain [MaxThreads+1];
  trq_pkg::trq_link_t prev_chain [MaxThreads+1];

  // control: sequencing, head/tail, result register
  trq_ctrl #(
    .MaxThreads(MaxThreads)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .rd_o     (rd),
    .wr_o     (wr),
    .next_rd_i(next_chain[MaxThreads]),
    .prev_rd_i(prev_chain[MaxThreads])
  );

  // read chain starts empty; each cell adds its link when addressed
  assign next_chain[0] = '0;
  assign prev_chain[0] = '0;

  for (genvar i = 0; i < MaxThreads; i++) begin : g_cell
    trq_cell #(
      .Index(i)
    ) u_cell (
      .clk_i       (clk_i),
      .rd_i        (rd),
      .wr_i        (wr),
      .next_chain_i(next_chain[i]),
      .prev_chain_i(prev_chain[i]),
      .next_chain_o(next_chain[i+1]),
      .prev_chain_o(prev_chain[i+1])
    );
  end

endmodule

// ===== design/trq_cell.sv =====
// ----------------------------------------------------------------------------
// trq_cell
// One thread slot: holds its next and prev links, folds them onto the read chain.
// ----------------------------------------------------------------------------
module trq_cell #(
  parameter int unsigned Index = 0
) (
  input  logic               clk_i,
  input  trq_pkg::trq_rd_t   rd_i,
  input  trq_pkg::trq_wr_t   wr_i,
  input  trq_pkg::trq_link_t next_chain_i,
  input  trq_pkg::trq_link_t prev_chain_i,
  output trq_pkg::trq_link_t next_chain_o,
  output trq_pkg::trq_link_t prev_chain_o
);

  trq_pkg::trq_link_t next_q, next_d;
  trq_pkg::trq_link_t prev_q, prev_d;
  logic hit_a, hit_b, hit_n0, hit_n1, hit_p;

  assign hit_a  = (32'(rd_i.addr_a) == Index);
  assign hit_b  = (32'(rd_i.addr_b) == Index);
  assign hit_n0 = wr_i.nxt0_en && (32'(wr_i.nxt0_addr) == Index);
  assign hit_n1 = wr_i.nxt1_en && (32'(wr_i.nxt1_addr) == Index);
  assign hit_p  = wr_i.prv_en && (32'(wr_i.prv_addr) == Index);

  always_comb begin
    next_d = next_q;
    if (hit_n1) begin
      next_d = wr_i.nxt1_data;
    end else if (hit_n0) begin
      next_d = wr_i.nxt0_data;
    end
    prev_d = hit_p ? wr_i.prv_data : prev_q;
  end

  // link store: undefined until first written
  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    prev_q <= prev_d;
  end

  assign next_chain_o = next_chain_i | (hit_a ? next_q : '0);
  assign prev_chain_o = prev_chain_i | (hit_b ? prev_q : '0);

endmodule

// ===== design/trq_ctrl.sv =====
// ----------------------------------------------------------------------------
// trq_ctrl
// Sequencer: read links, then update links, head and tail; result register.
// ----------------------------------------------------------------------------
module trq_ctrl #(
  parameter int unsigned MaxThreads = trq_pkg::MaxThreadsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  trq_pkg::trq_item_t   item_i,
  output logic                 done_o,
  output trq_pkg::trq_result_t result_o,
  output trq_pkg::trq_rd_t     rd_o,
  output trq_pkg::trq_wr_t     wr_o,
  input  trq_pkg::trq_link_t   next_rd_i,
  input  trq_pkg::trq_link_t   prev_rd_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRd   = 2'd1;
  localparam logic [1:0] StWr   = 2'd2;

  logic [1:0] state_q, state_d;
  trq_pkg::trq_item_t op_q;
  trq_pkg::trq_link_t rn_q, rp_q;
  logic [trq_pkg::IdW-1:0] head_q, head_d, tail_q, tail_d;
  logic has_q, has_d;
  logic done_q;
  trq_pkg::trq_result_t res_q, res_d;
  trq_pkg::trq_wr_t wr;
  logic accept, id_ok, took, ok_n, ok_p;

  function automatic logic link_ok(trq_pkg::trq_link_t l);
    return l.valid && (32'(l.idx) < MaxThreads);
  endfunction

  assign busy_o = (state_q == StRd);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  state_d = accept ? StRd : StIdle;
      StRd:    state_d = StWr;
      StWr:    state_d = accept ? StRd : StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      head_q  <= '0;
      tail_q  <= '0;
      has_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      has_q   <= has_d;
      done_q  <= (state_q == StWr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= item_i;
    end
    if (state_q == StRd) begin
      rn_q <= next_rd_i;
      rp_q <= prev_rd_i;
    end
    if (state_q == StWr) begin
      res_q <= res_d;
    end
  end

  // take walks from the head, remove looks at the thread itself
  assign rd_o.addr_a = (op_q.kind == trq_pkg::KindTake) ? head_q : op_q.thread_id;
  assign rd_o.addr_b = op_q.thread_id;

  assign id_ok = (32'(op_q.thread_id) < MaxThreads);
  assign ok_n  = link_ok(rn_q);
  assign ok_p  = link_ok(rp_q);

  always_comb begin
    wr     = '0;
    head_d = head_q;
    tail_d = tail_q;
    has_d  = has_q;
    took   = 1'b0;
    if (state_q == StWr) begin
      unique case (op_q.kind)
        trq_pkg::KindAppend: begin
          if (id_ok) begin
            wr.prv_en    = 1'b1;
            wr.prv_addr  = op_q.thread_id;
            wr.nxt1_en   = 1'b1;
            wr.nxt1_addr = op_q.thread_id;
            tail_d       = op_q.thread_id;
            if (!has_q) begin
              head_d = op_q.thread_id;
              has_d  = 1'b1;
            end else begin
              wr.nxt0_en        = (32'(tail_q) < MaxThreads);
              wr.nxt0_addr      = tail_q;
              wr.nxt0_data      = '{valid: 1'b1, idx: op_q.thread_id};
              wr.prv_data       = '{valid: 1'b1, idx: tail_q};
            end
          end
        end
        trq_pkg::KindTake: begin
          if (has_q) begin
            took = 1'b1;
            if (head_q != tail_q && ok_n) begin
              wr.prv_en   = 1'b1;
              wr.prv_addr = rn_q.idx;
              head_d      = rn_q.idx;
            end else begin
              has_d  = 1'b0;
              head_d = '0;
              tail_d = '0;
            end
          end
        end
        trq_pkg::KindRemove: begin
          if (id_ok) begin
            if (ok_p) begin
              wr.nxt0_en   = 1'b1;
              wr.nxt0_addr = rp_q.idx;
              wr.nxt0_data = ok_n ? rn_q : '0;
            end
            if (ok_n) begin
              wr.prv_en   = 1'b1;
              wr.prv_addr = rn_q.idx;
              wr.prv_data = ok_p ? rp_q : '0;
            end
            if (has_q && head_q == op_q.thread_id) begin
              if (ok_n) begin
                head_d = rn_q.idx;
              end else begin
                has_d  = 1'b0;
                head_d = '0;
              end
            end
            if (has_q && tail_q == op_q.thread_id) begin
              tail_d = ok_p ? rp_q.idx : '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign wr_o = wr;

  always_comb begin
    res_d.taken_valid = took;
    res_d.taken_id    = took ? head_q : '0;
    res_d.now_empty   = !has_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_rd_then_wr, state_q == StRd, state_q == StWr, "read not followed by update")
  `ASSERT_NEXT(a_wr_gives_done, state_q == StWr, done_q, "update gave no result")
  `ASSERT_IMPL(a_done_from_wr, done_q, $past(state_q) == StWr, "result without update")
  `ASSERT_IMPL(a_empty_flag, done_q, res_q.now_empty == !has_q, "empty flag disagrees")
  `ASSERT_IMPL(a_no_id, done_q && !res_q.taken_valid, res_q.taken_id == '0, "stray id")

endmodule
